// ===== src/swm_pkg.sv =====
// Shared types and constants for the sliding-window median core.
// Used by swm_cell and sliding_window_median_core; depends on nothing.

package swm_pkg;

    // Largest window the cell row is built for.
    localparam int WINDOW_MAX = 32;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int CFG_W    = 6;

    // Ring slot tag width and fill counter width follow from the row length.
    localparam int TAG_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(3);

    // Values broadcast from the control logic to every cell.
    typedef struct packed {
        logic                upd;
        logic                full;
        logic [SAMPLE_W-1:0] sample;
        logic [TAG_W-1:0]    ptr;
    } cell_bcast_t;

    // What a cell shows to its neighbors.
    typedef struct packed {
        logic                valid;
        logic                le;
        logic                rm;
        logic [SAMPLE_W-1:0] value;
        logic [TAG_W-1:0]    tag;
    } cell_out_t;

endpackage

// ===== src/swm_cell.sv =====
// One cell of the sorted row: holds one window sample and its ring slot tag.
// Depends on swm_pkg for cell_bcast_t and cell_out_t.

module swm_cell
    import swm_pkg::*;
(
    input  logic        clk,
    input  cell_bcast_t bc,
    input  logic        valid,
    input  cell_out_t   left,
    input  cell_out_t   right,
    input  logic        rmb_in,
    output logic        rmb_out,
    output cell_out_t   self_out
);

    logic [SAMPLE_W-1:0] value_reg;
    logic [SAMPLE_W-1:0] value_next;
    logic [TAG_W-1:0]    tag_reg;
    logic [TAG_W-1:0]    tag_next;
    logic                shift_here;
    cell_out_t           cur;
    cell_out_t           prv;

    always_comb
    begin
        self_out.valid = valid;
        self_out.le    = valid && ($signed(value_reg) <= $signed(bc.sample));
        self_out.rm    = valid && bc.full && (tag_reg == bc.ptr);
        self_out.value = value_reg;
        self_out.tag   = tag_reg;

        // Once the evicted entry lies at or below this cell, the row closes up
        // and this slot sees the entry to its right.
        shift_here = rmb_in | self_out.rm;
        cur        = shift_here ? right : self_out;
        prv        = rmb_in ? self_out : left;

        if (cur.le)
        begin
            value_next = cur.value;
            tag_next   = cur.tag;
        end
        else if (prv.le)
        begin
            value_next = bc.sample;
            tag_next   = bc.ptr;
        end
        else
        begin
            value_next = prv.value;
            tag_next   = prv.tag;
        end
    end

    assign rmb_out = shift_here;

    always_ff @(posedge clk)
    begin
        if (bc.upd)
        begin
            value_reg <= value_next;
            tag_reg   <= tag_next;
        end
    end

endmodule

// ===== src/sliding_window_median_core.sv =====
// Top level of the sliding-window median core: control, cell row and output register.
// Depends on swm_pkg and swm_cell.
//
// Usage:
// The input channel (in_valid/in_ready) carries one signed 32-bit sample and a
// restart flag per transfer. Restart empties the window before the sample is
// taken in. The output channel (out_valid/out_ready) carries median_x2, twice
// the median of the last window_size samples, so even windows stay exact.
// No result is produced until the window holds window_size samples.
// The configuration channel (cfg_valid/cfg_ready) writes window_size; zero acts
// as one and values above 32 act as 32. A write also empties the window, and
// it is meant to happen only while the core is idle.
// The cell row is updated at the edge that accepts a sample, and the result is
// registered from the row at a later edge, once the output register is free.
// Throughput is one sample per cycle while the output is not stalled: every cell
// decides its new contents from itself, its two neighbors and the eviction chain
// from the cells below, which inserts the new sample and evicts the oldest one at once.
// Reset leaves window_size at 3 and the window empty. When the receiver stalls,
// one result waits in the output register and one more in the cell row; after
// that in_ready drops until the output register is drained.

module sliding_window_median_core
    import swm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                restart,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [MEDIAN_W-1:0] median_x2,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    window_size
);

    // Control state.
    logic [CFG_W-1:0]    win_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    fill_next;
    logic [TAG_W-1:0]    ptr_reg;
    logic [TAG_W-1:0]    ptr_next;
    logic                pend_reg;
    logic                out_valid_reg;
    logic [MEDIAN_W-1:0] median_reg;

    logic [CNT_W-1:0]    win_len;
    logic [CNT_W-1:0]    fill_eff;
    logic [TAG_W-1:0]    ptr_eff;
    logic [CNT_W-1:0]    ptr_inc;
    logic                full_eff;
    logic                has_result;
    logic                in_xfer;
    logic                cfg_xfer;
    logic                out_load;

    cell_bcast_t         bc;
    cell_out_t           cell_out [WINDOW_MAX];
    logic                cell_valid [WINDOW_MAX];
    logic [WINDOW_MAX:0] rm_chain;
    logic [WINDOW_MAX-1:0] rm_vec;
    cell_out_t           edge_left;
    cell_out_t           edge_right;

    logic [TAG_W-1:0]    mid_lo;
    logic [TAG_W-1:0]    mid_hi;
    logic [SAMPLE_W-1:0] lo_val;
    logic [SAMPLE_W-1:0] hi_val;

    // Handshakes. A sample may enter whenever the result of the previous one
    // can move into the output register in the same cycle.
    assign out_load  = pend_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_reg || out_load;
    assign cfg_ready = !pend_reg;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_valid = out_valid_reg;
    assign median_x2 = median_reg;

    // Active window length, with zero treated as one and saturation at the row length.
    always_comb
    begin
        if (win_reg == '0)
            win_len = CNT_W'(1);
        else if (int'(win_reg) > WINDOW_MAX)
            win_len = CNT_W'(WINDOW_MAX);
        else
            win_len = CNT_W'(win_reg);
    end

    // Window bookkeeping for the sample on the input port.
    always_comb
    begin
        fill_eff = restart ? '0 : fill_reg;
        ptr_eff  = restart ? '0 : ptr_reg;
        if (CNT_W'(ptr_eff) >= win_len)
            ptr_eff = '0;
        full_eff = (fill_eff >= win_len);
        ptr_inc  = CNT_W'(ptr_eff) + CNT_W'(1);
        ptr_next = (ptr_inc >= win_len) ? '0 : ptr_inc[TAG_W-1:0];
        fill_next = full_eff ? win_len : fill_eff + CNT_W'(1);
        has_result = (fill_next >= win_len);
    end

    assign bc.upd    = in_xfer;
    assign bc.full   = full_eff;
    assign bc.sample = sample;
    assign bc.ptr    = ptr_eff;

    // Row boundaries: left of the first cell everything counts as below the
    // new sample, right of the last cell nothing is valid.
    always_comb
    begin
        edge_left       = '0;
        edge_left.valid = 1'b1;
        edge_left.le    = 1'b1;
        edge_right      = '0;
    end

    assign rm_chain[0] = 1'b0;

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        assign cell_valid[i] = (CNT_W'(i) < fill_eff);
        assign rm_vec[i]     = cell_out[i].rm;

        swm_cell u_cell
        (
            .clk      (clk),
            .bc       (bc),
            .valid    (cell_valid[i]),
            .left     ((i == 0) ? edge_left : cell_out[(i == 0) ? 0 : i - 1]),
            .right    ((i == WINDOW_MAX - 1) ? edge_right
                                             : cell_out[(i == WINDOW_MAX - 1) ? i : i + 1]),
            .rmb_in   (rm_chain[i]),
            .rmb_out  (rm_chain[i+1]),
            .self_out (cell_out[i])
        );
    end

    // Middle taps: the same cell for an odd window, two adjacent cells for an even one.
    always_comb
    begin
        mid_lo = TAG_W'((win_len - CNT_W'(1)) >> 1);
        mid_hi = TAG_W'(win_len >> 1);
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            if (TAG_W'(i) == mid_lo)
                lo_val = lo_val | cell_out[i].value;
            if (TAG_W'(i) == mid_hi)
                hi_val = hi_val | cell_out[i].value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= WINDOW_RESET;
            fill_reg      <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_xfer)
            begin
                win_reg  <= window_size;
                fill_reg <= '0;
                ptr_reg  <= '0;
            end
            else if (in_xfer)
            begin
                fill_reg <= fill_next;
                ptr_reg  <= ptr_next;
            end

            if (in_xfer)
                pend_reg <= has_result;
            else if (out_load)
                pend_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // The result is read from the row into the output register when a pending result is loaded.
    always_ff @(posedge clk)
    begin
        if (out_load)
            median_reg <= {lo_val[SAMPLE_W-1], lo_val} + {hi_val[SAMPLE_W-1], hi_val};
    end

    // The fill count never passes the active window length.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= win_len)
        else $error("fill count exceeds window length");

    // The ring pointer always names a slot inside the window.
    assert property (@(posedge clk) disable iff (!rst_n) CNT_W'(ptr_reg) < win_len)
        else $error("ring pointer outside window");

    // A full window evicts exactly one cell for each accepted sample.
    assert property (@(posedge clk) disable iff (!rst_n) (in_xfer && full_eff) |-> $onehot(rm_vec))
        else $error("eviction did not match exactly one cell");

    // A sample that completes the window leaves a result waiting.
    assert property (@(posedge clk) disable iff (!rst_n) (in_xfer && has_result) |=> pend_reg)
        else $error("result lost after accepted sample");

endmodule

// ===== test/sliding_window_median_core_test.sv =====
// Self-checking testbench for sliding_window_median_core: directed table, then random phases.
// Depends on swm_pkg and the core RTL; the running median is predicted inside the bench.
`timescale 1ns / 1ps

module sliding_window_median_core_test
    import swm_pkg::*;
();

    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int DIR_N         = 23;

    // How a directed row is checked: by the predictor, as no result, or by a typed value.
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_VALUE} check_kind_t;

    typedef struct packed {
        logic                wr_cfg;
        logic [CFG_W-1:0]    cfg;
        logic [SAMPLE_W-1:0] smp;
        logic                rst;
        check_kind_t         chk;
        logic [MEDIAN_W-1:0] val;
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample;
    logic                restart;
    logic                out_valid;
    logic                out_ready;
    logic [MEDIAN_W-1:0] median_x2;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CFG_W-1:0]    window_size;

    // Predicted state of the filter.
    int                         win_cfg;
    logic signed [SAMPLE_W-1:0] hist_ring [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] sorted_vals [WINDOW_MAX];
    int                         held;
    int                         slot;

    logic [MEDIAN_W-1:0] median_queue [$];
    stim_row_t           dir_rows [0:DIR_N-1];

    int  cycle_count;
    int  fail_count;
    int  items_sent;
    int  medians_checked;
    int  cfg_writes;
    int  stall_left;
    bit  rx_no_stall;

    sliding_window_median_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample      (sample),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .median_x2   (median_x2),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .window_size (window_size)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timed out after %0d cycles.", cycle_count);
            $display("sliding_window_median_core_test: FAIL");
            $finish;
        end
    end

    function automatic int eff_len();
        if (win_cfg == 0)
            return 1;
        if (win_cfg > WINDOW_MAX)
            return WINDOW_MAX;
        return win_cfg;
    endfunction

    // Append one expected median at the tail of the scoreboard.
    function automatic void queue_median(input logic [MEDIAN_W-1:0] m);
        median_queue.insert(median_queue.size(), m);
    endfunction

    // Insert v into the first n sorted entries, keeping them ascending.
    task automatic sorted_insert(input int n, input logic signed [SAMPLE_W-1:0] v);
        int i;
        i = n;
        while (i > 0 && sorted_vals[i-1] > v)
        begin
            sorted_vals[i] = sorted_vals[i-1];
            i--;
        end
        sorted_vals[i] = v;
    endtask

    // One sample through the running median: evict the oldest, insert the new one,
    // and report twice the median once the window is full.
    task automatic predict_median(input logic [SAMPLE_W-1:0] smp, input logic rst,
                                  output bit produced, output logic signed [MEDIAN_W-1:0] med);
        int                         k;
        int                         i;
        int                         pos;
        logic signed [SAMPLE_W-1:0] v;
        logic signed [MEDIAN_W-1:0] lo;
        logic signed [MEDIAN_W-1:0] hi;
        v = smp;
        k = eff_len();
        produced = 1'b0;
        med = '0;
        if (rst)
        begin
            held = 0;
            slot = 0;
        end
        if (slot >= k)
            slot = 0;
        if (held >= k)
        begin
            pos = k;
            for (i = 0; i < k; i++)
            begin
                if (sorted_vals[i] == hist_ring[slot])
                begin
                    pos = i;
                    break;
                end
            end
            for (i = pos; i + 1 < k; i++)
                sorted_vals[i] = sorted_vals[i+1];
            sorted_insert(k - 1, v);
            held = k;
        end
        else
        begin
            sorted_insert(held, v);
            held++;
        end
        hist_ring[slot] = v;
        slot++;
        if (slot >= k)
            slot = 0;
        if (held >= k)
        begin
            produced = 1'b1;
            if (k % 2 == 1)
            begin
                lo = sorted_vals[k/2];
                med = lo + lo;
            end
            else
            begin
                lo = sorted_vals[k/2-1];
                hi = sorted_vals[k/2];
                med = lo + hi;
            end
        end
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4, 5: return SAMPLE_W'($urandom_range(0, 16)) - SAMPLE_W'(8);
            6: return {SAMPLE_W{$urandom_range(0, 1) == 1}};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] draw_window();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_W'($urandom_range(33, 63));
            2: return CFG_W'(32);
            3: return CFG_W'(31);
            default: return CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Offer one sample after an idle gap set by gap, hold it until the transfer, then predict.
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic rst, input int gap,
                               input check_kind_t chk, input logic [MEDIAN_W-1:0] typed);
        bit                         produced;
        logic signed [MEDIAN_W-1:0] med;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        sample   <= smp;
        restart  <= rst;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
        predict_median(smp, rst, produced, med);
        if (chk == CHK_VALUE)
            queue_median(typed);
        else if (chk == CHK_MODEL && produced)
            queue_median(med);
    endtask

    // The window size is only written with the core idle: every median drained and
    // any sample that yields nothing given time to leave the cell row.
    task automatic write_window(input logic [CFG_W-1:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        while (median_queue.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid   <= 1'b1;
        window_size <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        win_cfg = val;
        held = 0;
        slot = 0;
        cfg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: out_ready follows the stall drawn after each result transfer.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (median_queue.size() == 0)
            begin
                $error("median_x2 unexpected: expected none, actual %h", median_x2);
                fail_count++;
            end
            else
            begin
                if (median_x2 !== median_queue[0])
                begin
                    $error("median_x2 mismatch: expected %h, actual %h",
                           median_queue[0], median_x2);
                    fail_count++;
                end
                void'(median_queue.pop_front());
                medians_checked++;
            end
            stall_left = rx_no_stall ? 0 : $urandom_range(0, 5);
        end
    end

    initial
    begin
        int          r;
        int          n;
        int          i;
        int          random_sent;
        bit          tx_no_idle;
        stim_row_t   row;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample      = '0;
        restart     = 1'b0;
        cfg_valid   = 1'b0;
        window_size = WINDOW_RESET;
        out_ready   = 1'b0;
        cycle_count = 0;
        fail_count  = 0;
        items_sent  = 0;
        medians_checked = 0;
        cfg_writes  = 0;
        stall_left  = 0;
        rx_no_stall = 1'b0;
        win_cfg     = int'(WINDOW_RESET);
        held        = 0;
        slot        = 0;

        // Directed rows: reset window of three, then windows of one, zero (acts as one),
        // two at the sample extremes, four with repeated values, and a saturated size.
        dir_rows = '{
            '{1'b0, 6'd0,  32'd5,          1'b0, CHK_NONE,  33'd0},
            '{1'b0, 6'd0,  -32'sd7,        1'b0, CHK_NONE,  33'd0},
            '{1'b0, 6'd0,  32'd100,        1'b0, CHK_VALUE, 33'd10},
            '{1'b0, 6'd0,  32'h7FFF_FFFF,  1'b0, CHK_MODEL, 33'd0},
            '{1'b0, 6'd0,  32'd1,          1'b1, CHK_NONE,  33'd0},
            '{1'b0, 6'd0,  32'd2,          1'b0, CHK_NONE,  33'd0},
            '{1'b0, 6'd0,  32'd3,          1'b0, CHK_VALUE, 33'd4},
            '{1'b1, 6'd1,  32'h7FFF_FFFF,  1'b0, CHK_VALUE, 33'h0_FFFF_FFFE},
            '{1'b0, 6'd0,  32'h8000_0000,  1'b0, CHK_VALUE, 33'h1_0000_0000},
            '{1'b0, 6'd0,  32'hFFFF_FFFF,  1'b0, CHK_VALUE, 33'h1_FFFF_FFFE},
            '{1'b0, 6'd0,  32'd0,          1'b1, CHK_VALUE, 33'd0},
            '{1'b1, 6'd0,  32'd3,          1'b0, CHK_VALUE, 33'd6},
            '{1'b1, 6'd2,  32'h7FFF_FFFF,  1'b0, CHK_NONE,  33'd0},
            '{1'b0, 6'd0,  32'h7FFF_FFFF,  1'b0, CHK_VALUE, 33'h0_FFFF_FFFE},
            '{1'b0, 6'd0,  32'h8000_0000,  1'b0, CHK_MODEL, 33'd0},
            '{1'b0, 6'd0,  32'h8000_0000,  1'b0, CHK_VALUE, 33'h1_0000_0000},
            '{1'b1, 6'd4,  32'd7,          1'b0, CHK_NONE,  33'd0},
            '{1'b0, 6'd0,  32'd7,          1'b0, CHK_NONE,  33'd0},
            '{1'b0, 6'd0,  -32'sd3,        1'b0, CHK_NONE,  33'd0},
            '{1'b0, 6'd0,  32'd7,          1'b0, CHK_MODEL, 33'd0},
            '{1'b0, 6'd0,  32'd7,          1'b0, CHK_MODEL, 33'd0},
            '{1'b0, 6'd0,  32'd9,          1'b1, CHK_NONE,  33'd0},
            '{1'b1, 6'd63, 32'd1,          1'b0, CHK_NONE,  33'd0}
        };

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_N; i++)
        begin
            row = dir_rows[i];
            if (row.wr_cfg)
                write_window(row.cfg);
            send_sample(row.smp, row.rst, $urandom_range(0, 5), row.chk, row.val);
        end

        // Random phases: each writes a fresh window size and then streams twice the window length
        // plus 20 to 120 samples, with rare restarts and mixed idling.
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            write_window(draw_window());
            tx_no_idle  = ($urandom_range(0, 3) == 0);
            rx_no_stall = ($urandom_range(0, 3) == 0);
            n = 2 * eff_len() + $urandom_range(20, 120);
            for (r = 0; r < n; r++)
            begin
                send_sample(draw_sample(), ($urandom_range(0, 39) == 0),
                            tx_no_idle ? 0 : $urandom_range(0, 5), CHK_MODEL, '0);
                random_sent++;
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (median_queue.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Streamed %0d samples over %0d window size writes; %0d medians compared.",
                 items_sent, cfg_writes, medians_checked);
        if (fail_count == 0)
            $display("sliding_window_median_core_test: PASS");
        else
            $display("sliding_window_median_core_test: FAIL");
        $finish;
    end

endmodule
